/* design/cor_pkg.sv */
// cor_pkg: shared types, constants and helpers for the camera orbit rotation block
// used by cor_cordic and camera_orbit_rotation_top; no dependencies

package cor_pkg;

    // default field widths
    localparam int POS_W_DEF  = 24;
    localparam int VEC_W_DEF  = 16;
    localparam int ANGLE_W    = 16;
    localparam int MODE_W     = 2;

    // fixed-point formats
    localparam int MAT_FRAC    = 24;
    localparam int MAT_W       = 32;
    localparam int ACC_W       = 64;
    localparam int TRIG_W      = 27;
    localparam int CORDIC_FRAC = 30;

    // cordic constants, angle in Q.16
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int CX_W         = 34;
    localparam int Z_W          = 20;
    localparam logic signed [CX_W-1:0] CORDIC_X0   = 34'sd652032874;
    localparam logic signed [Z_W-1:0]  ANG_PI      = 20'sd205887;
    localparam logic signed [Z_W-1:0]  ANG_HALF_PI = 20'sd102944;

    // configuration port
    localparam int ADDR_W   = 6;
    localparam int NUM_REGS = 6;
    localparam logic [2:0] REG_POS_X    = 3'd0;
    localparam logic [2:0] REG_POS_Y    = 3'd1;
    localparam logic [2:0] REG_POS_Z    = 3'd2;
    localparam logic [2:0] REG_HEADING  = 3'd3;
    localparam logic [2:0] REG_UPWARD   = 3'd4;
    localparam logic [2:0] REG_SIDEWAYS = 3'd5;

    typedef enum logic [MODE_W-1:0] {
        MODE_RELOAD    = 2'd0,
        MODE_ROT_UP    = 2'd1,
        MODE_ROT_RIGHT = 2'd2,
        MODE_HOLD      = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIG,
        ST_US,
        ST_MAT,
        ST_POS,
        ST_VROW,
        ST_LEN,
        ST_SQRT,
        ST_DIV,
        ST_WB,
        ST_DONE
    } state_t;

    // sine/cosine result from the cordic unit
    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] sin_v;
        logic signed [TRIG_W-1:0] cos_v;
    } trig_t;

    // arctangent table, Q.16
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [STEP_W-1:0] idx);
        logic signed [Z_W-1:0] r;
        unique case (idx)
            4'd0:    r = 20'sd51472;
            4'd1:    r = 20'sd30386;
            4'd2:    r = 20'sd16055;
            4'd3:    r = 20'sd8150;
            4'd4:    r = 20'sd4091;
            4'd5:    r = 20'sd2047;
            4'd6:    r = 20'sd1024;
            4'd7:    r = 20'sd512;
            4'd8:    r = 20'sd256;
            4'd9:    r = 20'sd128;
            4'd10:   r = 20'sd64;
            4'd11:   r = 20'sd32;
            4'd12:   r = 20'sd16;
            4'd13:   r = 20'sd8;
            4'd14:   r = 20'sd4;
            default: r = 20'sd2;
        endcase
        return r;
    endfunction

    // round a Q.24 product sum back to the operand format
    function automatic logic signed [ACC_W-1:0] rnd_mat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] half;
        half = 64'sd1 <<< (MAT_FRAC - 1);
        return (v + half) >>> MAT_FRAC;
    endfunction

endpackage

/* design/cor_cordic.sv */
// cor_cordic: 16-step rotation-mode cordic giving sine and cosine in Q.24
// depends on cor_pkg

module cor_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [cor_pkg::ANGLE_W-1:0]  angle,
    output cor_pkg::trig_t                      trig
);
    import cor_pkg::*;

    localparam int RND_SH = CORDIC_FRAC - MAT_FRAC;

    logic                     busy_reg;
    logic                     fin_reg;
    logic                     done_reg;
    logic [STEP_W-1:0]        cnt_reg;
    logic signed [CX_W-1:0]   x_reg;
    logic signed [CX_W-1:0]   y_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic                     neg_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [TRIG_W-1:0] cos_reg;

    logic signed [Z_W-1:0]    z_start;
    logic signed [CX_W-1:0]   dx;
    logic signed [CX_W-1:0]   dy;
    logic signed [CX_W-1:0]   x_fin;
    logic signed [CX_W-1:0]   y_fin;
    logic signed [CX_W-1:0]   rnd_half;

    // angle to Q.16
    assign z_start  = Z_W'(angle) <<< 3;
    assign dx       = y_reg >>> cnt_reg;
    assign dy       = x_reg >>> cnt_reg;
    assign x_fin    = neg_reg ? -x_reg : x_reg;
    assign y_fin    = neg_reg ? -y_reg : y_reg;
    assign rnd_half = CX_W'(1) <<< (RND_SH - 1);

    // control: iteration count and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    // datapath: range fold, micro-rotations, final rounding
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= CORDIC_X0;
            y_reg <= '0;
            priority if (z_start > ANG_HALF_PI)
            begin
                z_reg   <= z_start - ANG_PI;
                neg_reg <= 1'b1;
            end
            else if (z_start < -ANG_HALF_PI)
            begin
                z_reg   <= z_start + ANG_PI;
                neg_reg <= 1'b1;
            end
            else
            begin
                z_reg   <= z_start;
                neg_reg <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_q16(cnt_reg);
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_q16(cnt_reg);
            end
        end
        if (fin_reg)
        begin
            cos_reg <= TRIG_W'((x_fin + rnd_half) >>> RND_SH);
            sin_reg <= TRIG_W'((y_fin + rnd_half) >>> RND_SH);
        end
    end

    assign trig.done  = done_reg;
    assign trig.sin_v = sin_reg;
    assign trig.cos_v = cos_reg;

endmodule

/* design/camera_orbit_rotation_top.sv */
// camera_orbit_rotation_top: camera frame kept in registers, rotated about up or right axis
// depends on cor_pkg and cor_cordic
//
//  channel    direction  handshake                 contents
//  s_axis     in         tvalid/tready             tuser: mode; tdata: pivot x,y,z, turn_angle
//  m_axis     out        tvalid/tready             tdata: pos, dir, up, right
//  apb        in         psel/penable/pwrite       six start_* registers, 8-byte stride
//
//  a reload or hold step goes from idle straight to the final step; a rotation computes
//  sine/cosine, then the matrix and the position, then rotates and rescales the two vectors
//  in turn; the single shared multiplier, the bit-pair square root and the restoring divider
//  set the length of a rotation
//  one item is in work at a time; s_axis_tready is high only while idle
//  a finished frame waits in the output register; a stalled m_axis holds the block in its last step
//  reset loads the default frame and the default start registers

module camera_orbit_rotation_top #(
    parameter int POSITION_WIDTH = cor_pkg::POS_W_DEF,
    parameter int VECTOR_WIDTH   = cor_pkg::VEC_W_DEF
) (
    input  logic clk,
    input  logic rst_n,
    // fields from bit 0 up: pivot_x, pivot_y, pivot_z, turn_angle
    input  logic [((3*POSITION_WIDTH+cor_pkg::ANGLE_W+7)/8)*8-1:0] s_axis_tdata,
    // fields: mode
    input  logic [cor_pkg::MODE_W-1:0] s_axis_tuser,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // fields from bit 0 up: pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, up_x, up_y, up_z,
    // right_x, right_y, right_z
    output logic [((3*POSITION_WIDTH+9*VECTOR_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cor_pkg::ADDR_W-1:0] paddr,
    input  logic [((((3*VECTOR_WIDTH > POSITION_WIDTH) ? 3*VECTOR_WIDTH : POSITION_WIDTH)
                   +31)/32)*32-1:0] pwdata,
    output logic [((((3*VECTOR_WIDTH > POSITION_WIDTH) ? 3*VECTOR_WIDTH : POSITION_WIDTH)
                   +31)/32)*32-1:0] prdata,
    output logic                       pready
);
    import cor_pkg::*;

    localparam int PW      = POSITION_WIDTH;
    localparam int VW      = VECTOR_WIDTH;
    localparam int VF      = VW - 2;
    localparam int CFG_W   = (3*VW > PW) ? 3*VW : PW;
    localparam int PD_W    = ((CFG_W + 31) / 32) * 32;
    localparam int OUT_W   = ((3*PW + 9*VW + 7) / 8) * 8;
    localparam int MUL_W   = (PW + 1 > MAT_W) ? PW + 1 : MAT_W;
    localparam int RW      = VW + 7;
    localparam int LEN2_W  = 2 * RW;
    localparam int SQ_ITER = RW;
    localparam int QW      = VW;
    localparam int DIV_W   = 2 * VW + 6;
    localparam int KW      = $clog2(SQ_ITER);
    localparam int TM_SH   = 2 * VF - MAT_FRAC;
    localparam int TM_R    = (TM_SH > 0) ? TM_SH : 0;
    localparam int TM_L    = (TM_SH < 0) ? -TM_SH : 0;

    localparam logic [VW-1:0]    UNIT_V   = VW'(1) << VF;
    localparam logic [VW-1:0]    NUNIT_V  = ~UNIT_V + 1'b1;
    localparam logic [CFG_W-1:0] HEAD_RST = CFG_W'({ {VW{1'b0}}, {VW{1'b0}}, NUNIT_V });
    localparam logic [CFG_W-1:0] UP_RST   = CFG_W'({ {VW{1'b0}}, UNIT_V, {VW{1'b0}} });
    localparam logic [CFG_W-1:0] SIDE_RST = CFG_W'({ UNIT_V, {VW{1'b0}}, {VW{1'b0}} });
    localparam logic signed [ACC_W-1:0] POS_HI = (64'sd1 <<< (PW - 1)) - 64'sd1;
    localparam logic signed [ACC_W-1:0] POS_LO = -(64'sd1 <<< (PW - 1));

    // control state
    state_t           state_reg, state_next;
    mode_t            mode_reg;
    logic [1:0]       i_reg, j_reg;
    logic [KW-1:0]    k_reg;
    logic             ph_reg, sub_reg, ab_reg;
    logic             out_valid_reg;

    // configuration and camera frame
    logic [CFG_W-1:0]        cfg_reg [NUM_REGS];
    logic signed [PW-1:0]    pos_reg [3];
    logic signed [VW-1:0]    dir_reg [3];
    logic signed [VW-1:0]    up_reg  [3];
    logic signed [VW-1:0]    rgt_reg [3];

    // working registers
    logic signed [PW-1:0]     piv_reg  [3];
    logic signed [VW-1:0]     ax_reg   [3];
    logic signed [VW-1:0]     cur_reg  [3];
    logic signed [MAT_W-1:0]  us_reg   [3];
    logic signed [MAT_W-1:0]  m_reg    [9];
    logic signed [PW-1:0]     npos_reg [3];
    logic signed [RW-1:0]     rv_reg   [3];
    logic signed [MAT_W-1:0]  t_reg;
    logic signed [TRIG_W-1:0] s_reg, c_reg;
    logic signed [ACC_W-1:0]  prod_reg, acc_reg;
    logic [LEN2_W-1:0]        sq_n_reg, sq_res_reg, sq_bit_reg;
    logic [DIV_W-1:0]         rem_reg;
    logic [QW-1:0]            q_reg;
    logic [OUT_W-1:0]         out_data_reg;

    // combinational helpers
    logic                     in_xfer, cfg_wr, out_free;
    mode_t                    in_mode;
    logic [2:0]               cfg_idx;
    logic                     last_i, last_j;
    logic [3:0]               midx;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_full;
    logic signed [PW:0]       rel_j;
    logic signed [TRIG_W:0]   omc;
    logic signed [ACC_W-1:0]  tm, add_term, row_sum, row_rnd, pos_sum, pos_sat;
    logic [LEN2_W-1:0]        sq_try;
    logic [RW-1:0]            mag;
    logic [DIV_W-1:0]         num, trial;
    logic                     div_ge;
    logic [QW-1:0]            q_fin, q_clamp;
    logic signed [VW-1:0]     v_new;
    logic [OUT_W-1:0]         out_pack;
    trig_t                    trig;

    assign in_mode  = mode_t'(s_axis_tuser);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = paddr[ADDR_W-1:3];
    assign out_free = !out_valid_reg || m_axis_tready;
    assign last_i   = (i_reg == 2'd2);
    assign last_j   = (j_reg == 2'd2);
    assign midx     = {i_reg, 1'b0} + {2'b00, i_reg} + {2'b00, j_reg};

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign pready        = 1'b1;

    // sine and cosine unit
    cor_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_xfer && (in_mode == MODE_ROT_UP || in_mode == MODE_ROT_RIGHT)),
        .angle (s_axis_tdata[3*PW +: ANGLE_W]),
        .trig  (trig)
    );

    // register read back
    always_comb
    begin
        prdata = '0;
        if (cfg_idx < 3'(NUM_REGS))
            prdata = PD_W'(cfg_reg[cfg_idx]);
    end

    // shared multiplier operand selection
    always_comb
    begin
        rel_j = {pos_reg[j_reg][PW-1], pos_reg[j_reg]} - {piv_reg[j_reg][PW-1], piv_reg[j_reg]};
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_US:
            begin
                mul_a = MUL_W'(ax_reg[i_reg]);
                mul_b = MUL_W'(s_reg);
            end
            ST_MAT:
            begin
                mul_a = sub_reg ? MUL_W'(t_reg) : MUL_W'(ax_reg[i_reg]);
                mul_b = sub_reg ? MUL_W'(omc) : MUL_W'(ax_reg[j_reg]);
            end
            ST_POS:
            begin
                mul_a = MUL_W'(m_reg[midx]);
                mul_b = MUL_W'(rel_j);
            end
            ST_VROW:
            begin
                mul_a = MUL_W'(m_reg[midx]);
                mul_b = MUL_W'(cur_reg[j_reg]);
            end
            ST_LEN:
            begin
                mul_a = MUL_W'(rv_reg[i_reg]);
                mul_b = MUL_W'(rv_reg[i_reg]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // one minus cosine in q.24
    assign mul_full = mul_a * mul_b;
    assign omc      = ((TRIG_W+1)'(1) <<< MAT_FRAC) - (TRIG_W+1)'(c_reg);

    // matrix entry terms: diagonal cosine and skew sine products
    always_comb
    begin
        tm = (prod_reg >>> TM_R) <<< TM_L;
        unique case (midx)
            4'd0, 4'd4, 4'd8: add_term = ACC_W'(c_reg);
            4'd1:             add_term = -ACC_W'(us_reg[2]);
            4'd2:             add_term = ACC_W'(us_reg[1]);
            4'd3:             add_term = ACC_W'(us_reg[2]);
            4'd5:             add_term = -ACC_W'(us_reg[0]);
            4'd6:             add_term = -ACC_W'(us_reg[1]);
            4'd7:             add_term = ACC_W'(us_reg[0]);
            default:          add_term = '0;
        endcase
    end

    // row sums, position saturation
    always_comb
    begin
        row_sum = acc_reg + prod_reg;
        row_rnd = rnd_mat(row_sum);
        pos_sum = row_rnd + ACC_W'(piv_reg[i_reg]);
        priority if (pos_sum > POS_HI)
            pos_sat = POS_HI;
        else if (pos_sum < POS_LO)
            pos_sat = POS_LO;
        else
            pos_sat = pos_sum;
    end

    // square root step and divider step
    always_comb
    begin
        sq_try  = sq_res_reg + sq_bit_reg;
        mag     = rv_reg[i_reg][RW-1] ? RW'(-rv_reg[i_reg]) : RW'(rv_reg[i_reg]);
        num     = (DIV_W'(mag) << VF) + DIV_W'(sq_res_reg >> 1);
        trial   = DIV_W'(sq_res_reg) << k_reg;
        div_ge  = (rem_reg >= trial);
        q_fin   = q_reg | (div_ge ? (QW'(1) << k_reg) : '0);
        q_clamp = (q_fin > UNIT_V) ? UNIT_V : q_fin;
        v_new   = rv_reg[i_reg][RW-1] ? -$signed(q_clamp) : $signed(q_clamp);
    end

    // frame packing for the output transfer
    always_comb
    begin
        out_pack = '0;
        for (int n = 0; n < 3; n++)
        begin
            out_pack[n*PW +: PW]                = pos_reg[n];
            out_pack[3*PW + n*VW +: VW]         = dir_reg[n];
            out_pack[3*PW + 3*VW + n*VW +: VW]  = up_reg[n];
            out_pack[3*PW + 6*VW + n*VW +: VW]  = rgt_reg[n];
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_xfer)
                begin
                    if (in_mode == MODE_ROT_UP || in_mode == MODE_ROT_RIGHT)
                        state_next = ST_TRIG;
                    else
                        state_next = ST_DONE;
                end
            ST_TRIG:
                if (trig.done)
                    state_next = ST_US;
            ST_US:
                if (ph_reg && last_i)
                    state_next = ST_MAT;
            ST_MAT:
                if (ph_reg && sub_reg && last_i && last_j)
                    state_next = ST_POS;
            ST_POS:
                if (ph_reg && last_i && last_j)
                    state_next = ST_VROW;
            ST_VROW:
                if (ph_reg && last_i && last_j)
                    state_next = ST_LEN;
            ST_LEN:
                if (ph_reg && last_i)
                    state_next = ST_SQRT;
            ST_SQRT:
                if (k_reg == KW'(SQ_ITER - 1))
                    state_next = ST_DIV;
            ST_DIV:
                priority if (!ph_reg && sq_res_reg == '0)
                    state_next = ST_WB;
                else if (ph_reg && k_reg == '0 && last_i)
                    state_next = ST_WB;
            ST_WB:
                state_next = ab_reg ? ST_DONE : ST_VROW;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // sequencer counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_HOLD;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            ph_reg        <= 1'b0;
            sub_reg       <= 1'b0;
            ab_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (in_xfer)
                    begin
                        mode_reg <= in_mode;
                        i_reg    <= '0;
                        j_reg    <= '0;
                        ph_reg   <= 1'b0;
                        sub_reg  <= 1'b0;
                        ab_reg   <= 1'b0;
                    end
                ST_US, ST_LEN:
                begin
                    ph_reg <= ~ph_reg;
                    k_reg  <= '0;
                    if (ph_reg)
                        i_reg <= last_i ? 2'd0 : i_reg + 2'd1;
                end
                ST_MAT:
                begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg)
                    begin
                        sub_reg <= ~sub_reg;
                        if (sub_reg)
                        begin
                            j_reg <= last_j ? 2'd0 : j_reg + 2'd1;
                            if (last_j)
                                i_reg <= last_i ? 2'd0 : i_reg + 2'd1;
                        end
                    end
                end
                ST_POS, ST_VROW:
                begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg)
                    begin
                        j_reg <= last_j ? 2'd0 : j_reg + 2'd1;
                        if (last_j)
                            i_reg <= last_i ? 2'd0 : i_reg + 2'd1;
                    end
                end
                ST_SQRT:
                    k_reg <= k_reg + 1'b1;
                ST_DIV:
                    if (!ph_reg)
                    begin
                        if (sq_res_reg != '0)
                        begin
                            k_reg  <= KW'(QW - 1);
                            ph_reg <= 1'b1;
                        end
                    end
                    else if (k_reg == '0)
                    begin
                        ph_reg <= 1'b0;
                        i_reg  <= last_i ? 2'd0 : i_reg + 2'd1;
                    end
                    else
                        k_reg <= k_reg - 1'b1;
                ST_WB:
                begin
                    ab_reg <= 1'b1;
                    i_reg  <= '0;
                    j_reg  <= '0;
                    ph_reg <= 1'b0;
                end
                ST_DONE:
                    if (out_free)
                        out_valid_reg <= 1'b1;
                default:
                    ;
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_POS_X]    <= '0;
            cfg_reg[REG_POS_Y]    <= '0;
            cfg_reg[REG_POS_Z]    <= '0;
            cfg_reg[REG_HEADING]  <= HEAD_RST;
            cfg_reg[REG_UPWARD]   <= UP_RST;
            cfg_reg[REG_SIDEWAYS] <= SIDE_RST;
        end
        else if (cfg_wr && cfg_idx < 3'(NUM_REGS))
        begin
            if (cfg_idx <= REG_POS_Z)
                cfg_reg[cfg_idx] <= CFG_W'(pwdata[PW-1:0]);
            else
                cfg_reg[cfg_idx] <= CFG_W'(pwdata[3*VW-1:0]);
        end
    end

    // camera frame: reload, position commit, vector write back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < 3; n++)
            begin
                pos_reg[n] <= '0;
                dir_reg[n] <= HEAD_RST[(2-n)*VW +: VW];
                up_reg[n]  <= UP_RST[(2-n)*VW +: VW];
                rgt_reg[n] <= SIDE_RST[(2-n)*VW +: VW];
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    if (in_xfer && in_mode == MODE_RELOAD)
                    begin
                        for (int n = 0; n < 3; n++)
                        begin
                            pos_reg[n] <= cfg_reg[n][PW-1:0];
                            dir_reg[n] <= cfg_reg[REG_HEADING][(2-n)*VW +: VW];
                            up_reg[n]  <= cfg_reg[REG_UPWARD][(2-n)*VW +: VW];
                            rgt_reg[n] <= cfg_reg[REG_SIDEWAYS][(2-n)*VW +: VW];
                        end
                    end
                ST_POS:
                    if (ph_reg && last_i && last_j)
                    begin
                        pos_reg[0] <= npos_reg[0];
                        pos_reg[1] <= npos_reg[1];
                        pos_reg[2] <= PW'(pos_sat);
                    end
                ST_WB:
                    for (int n = 0; n < 3; n++)
                    begin
                        if (ab_reg)
                            dir_reg[n] <= cur_reg[n];
                        else if (mode_reg == MODE_ROT_UP)
                            rgt_reg[n] <= cur_reg[n];
                        else
                            up_reg[n] <= cur_reg[n];
                    end
                default:
                    ;
            endcase
        end
    end

    // working datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full[ACC_W-1:0];
        unique case (state_reg)
            ST_IDLE:
                if (in_xfer)
                begin
                    acc_reg <= '0;
                    for (int n = 0; n < 3; n++)
                    begin
                        piv_reg[n] <= s_axis_tdata[n*PW +: PW];
                        ax_reg[n]  <= (in_mode == MODE_ROT_UP) ? up_reg[n] : rgt_reg[n];
                    end
                end
            ST_TRIG:
                if (trig.done)
                begin
                    s_reg <= trig.sin_v;
                    c_reg <= trig.cos_v;
                end
            ST_US:
                if (ph_reg)
                    us_reg[i_reg] <= MAT_W'(prod_reg >>> VF);
            ST_MAT:
                if (ph_reg)
                begin
                    if (sub_reg)
                        m_reg[midx] <= MAT_W'((prod_reg >>> MAT_FRAC) + add_term);
                    else
                        t_reg <= MAT_W'(tm);
                end
            ST_POS:
                if (ph_reg)
                begin
                    acc_reg <= last_j ? '0 : row_sum;
                    if (last_j)
                        npos_reg[i_reg] <= PW'(pos_sat);
                    if (last_j && last_i)
                        for (int n = 0; n < 3; n++)
                            cur_reg[n] <= (mode_reg == MODE_ROT_UP) ? rgt_reg[n] : up_reg[n];
                end
            ST_VROW:
                if (ph_reg)
                begin
                    acc_reg <= last_j ? '0 : row_sum;
                    if (last_j)
                        rv_reg[i_reg] <= RW'(row_rnd);
                end
            ST_LEN:
                if (ph_reg)
                begin
                    acc_reg <= last_i ? '0 : row_sum;
                    if (last_i)
                    begin
                        sq_n_reg   <= LEN2_W'(row_sum);
                        sq_res_reg <= '0;
                        sq_bit_reg <= LEN2_W'(1) << (LEN2_W - 2);
                    end
                end
            ST_SQRT:
            begin
                if (sq_n_reg >= sq_try)
                begin
                    sq_n_reg   <= sq_n_reg - sq_try;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_reg <= sq_res_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            ST_DIV:
                if (!ph_reg)
                begin
                    rem_reg <= num;
                    q_reg   <= '0;
                end
                else
                begin
                    if (div_ge)
                        rem_reg <= rem_reg - trial;
                    q_reg <= q_fin;
                    if (k_reg == '0)
                        cur_reg[i_reg] <= v_new;
                end
            ST_WB:
                if (!ab_reg)
                    for (int n = 0; n < 3; n++)
                        cur_reg[n] <= dir_reg[n];
            ST_DONE:
                if (out_free)
                    out_data_reg <= out_pack;
            default:
                ;
        endcase
    end

    // a rotation request starts the sine/cosine phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (in_mode == MODE_ROT_UP || in_mode == MODE_ROT_RIGHT))
            |=> state_reg == ST_TRIG)
        else $error("rotation did not start the cordic phase");

    // the cordic reports only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        trig.done |-> state_reg == ST_TRIG)
        else $error("cordic result outside its phase");

    // a new output transfer comes only from the final step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == ST_DONE)
        else $error("output valid raised outside the final step");

endmodule

/* verif/camera_orbit_rotation_top_tb.sv */
// camera_orbit_rotation_top_tb: self-checking bench for the camera orbit rotation block
// predicts every frame from a behavioral copy of the rotation arithmetic; needs cor_pkg and the rtl
`timescale 1ns / 1ps

module camera_orbit_rotation_top_tb;
    import cor_pkg::*;

    localparam int POS_W    = 24;
    localparam int VEC_W    = 16;
    localparam int IN_W     = 88;
    localparam int OUT_W    = 216;
    localparam int UNIT     = 16384;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        mode_t                    mode;
        logic signed [POS_W-1:0]  piv[3];
        logic signed [15:0]       angle;
    } step_req_t;

    logic                clk;
    logic                rst_n;
    logic [IN_W-1:0]     s_axis_tdata;
    logic [MODE_W-1:0]   s_axis_tuser;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [63:0]         pwdata;
    logic [63:0]         prdata;
    logic                pready;

    // predictor state: start registers, position, and direction/up/right vectors
    logic [63:0]     start_regs[6];
    longint          frame_pos[3];
    longint          frame_vec[3][3];
    longint          rot_mat[3][3];
    longint          cordic_atan[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                         256, 128, 64, 32, 16, 8, 4, 2};

    step_req_t           pending_steps[$];
    logic [OUT_W-1:0]    frames_expected[$];
    step_req_t           cur_step;
    int                  send_gap;
    int                  recv_stall;
    int                  hold_left;
    bit                  hold_request;
    bit                  hold_done;
    bit                  idling_on;
    int                  mismatches;
    int                  frames_checked;
    int                  steps_sent;
    int                  rotations_sent;
    longint              cycle_count;

    camera_orbit_rotation_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock and cycle watchdog
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[camera_orbit_rotation_top] ERROR");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic longint sx(input logic [63:0] v, input int w);
        longint r;
        r = longint'(v & ((64'd1 << w) - 1));
        if (v[w-1])
            r = r - (longint'(1) << w);
        return r;
    endfunction

    function automatic void load_start_frame();
        for (int i = 0; i < 3; i++)
        begin
            frame_pos[i] = sx(start_regs[i], POS_W);
            for (int k = 0; k < 3; k++)
                frame_vec[k][i] = sx(start_regs[3+k] >> (VEC_W * (2 - i)), VEC_W);
        end
    endfunction

    function automatic longint round_q24(input longint v);
        return (v + (longint'(1) <<< 23)) >>> 24;
    endfunction

    // rotation-mode cordic with quadrant fold, sine/cosine rounded to q.24
    function automatic void sine_cosine(input longint ang13, output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit     neg;
        z = ang13 * 8;
        x = 652032874;
        y = 0;
        neg = 0;
        if (z > 102944)
        begin
            z = z - 205887;
            neg = 1;
        end
        else if (z < -102944)
        begin
            z = z + 205887;
            neg = 1;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - cordic_atan[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + cordic_atan[i];
            end
        end
        if (neg)
        begin
            x = -x;
            y = -y;
        end
        c = (x + 32) >>> 6;
        s = (y + 32) >>> 6;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // rotate one stored vector and bring it back to unit length; zero length keeps it
    function automatic void turn_unit_vector(input int k);
        longint r[3];
        longint unsigned len2, len, mag, q;
        len2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            r[i] = round_q24(rot_mat[i][0] * frame_vec[k][0] + rot_mat[i][1] * frame_vec[k][1]
                             + rot_mat[i][2] * frame_vec[k][2]);
            len2 = len2 + longint'(r[i] * r[i]);
        end
        len = floor_sqrt(len2);
        if (len != 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag = (r[i] < 0) ? -r[i] : r[i];
                q = (mag * UNIT + len / 2) / len;
                if (q > UNIT)
                    q = UNIT;
                frame_vec[k][i] = (r[i] < 0) ? -longint'(q) : longint'(q);
            end
        end
    endfunction

    // axis index 1 (up) or 2 (right); the other two vectors follow the rotation
    function automatic void orbit_frame(input int axis, input step_req_t st);
        longint s, c, omc, us[3], u[3], rot[3], v;
        sine_cosine(longint'(st.angle), s, c);
        omc = (longint'(1) << 24) - c;
        for (int i = 0; i < 3; i++)
        begin
            u[i] = frame_vec[axis][i];
            us[i] = (u[i] * s) >>> 14;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                rot_mat[i][j] = (((u[i] * u[j]) >>> 4) * omc) >>> 24;
        for (int i = 0; i < 3; i++)
            rot_mat[i][i] = rot_mat[i][i] + c;
        rot_mat[0][1] -= us[2];
        rot_mat[0][2] += us[1];
        rot_mat[1][0] += us[2];
        rot_mat[1][2] -= us[0];
        rot_mat[2][0] -= us[1];
        rot_mat[2][1] += us[0];
        for (int i = 0; i < 3; i++)
            rot[i] = round_q24(rot_mat[i][0] * (frame_pos[0] - st.piv[0])
                               + rot_mat[i][1] * (frame_pos[1] - st.piv[1])
                               + rot_mat[i][2] * (frame_pos[2] - st.piv[2]));
        for (int i = 0; i < 3; i++)
        begin
            v = rot[i] + st.piv[i];
            if (v > 8388607)
                v = 8388607;
            else if (v < -8388608)
                v = -8388608;
            frame_pos[i] = v;
        end
        turn_unit_vector(axis == 1 ? 2 : 1);
        turn_unit_vector(0);
    endfunction

    function automatic logic [OUT_W-1:0] predict_frame_step(input step_req_t st);
        logic [OUT_W-1:0] f;
        case (st.mode)
            MODE_RELOAD:    load_start_frame();
            MODE_ROT_UP:    orbit_frame(1, st);
            MODE_ROT_RIGHT: orbit_frame(2, st);
            default:        ;
        endcase
        f = '0;
        for (int i = 0; i < 3; i++)
        begin
            f[POS_W*i +: POS_W] = frame_pos[i][POS_W-1:0];
            for (int k = 0; k < 3; k++)
                f[3*POS_W + VEC_W*(3*k+i) +: VEC_W] = frame_vec[k][i][VEC_W-1:0];
        end
        return f;
    endfunction

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            send_gap      <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            // a transfer just happened: book its frame
            if (s_axis_tvalid)
            begin
                frames_expected.push_back(predict_frame_step(cur_step));
                steps_sent <= steps_sent + 1;
            end
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_steps.size() > 0)
            begin
                cur_step = pending_steps.pop_front();
                s_axis_tdata  <= {cur_step.angle, cur_step.piv[2], cur_step.piv[1],
                                  cur_step.piv[0]};
                s_axis_tuser  <= cur_step.mode;
                s_axis_tvalid <= 1'b1;
                if (idling_on && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 11);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ---------------- receiver and monitor ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_stall    <= 0;
            hold_left     <= 0;
            hold_done     <= 0;
        end
        else if (hold_request && !hold_done)
        begin
            hold_done     <= 1'b1;
            hold_left     <= 1500;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (recv_stall > 0)
        begin
            recv_stall    <= recv_stall - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (idling_on && $urandom_range(0, 5) == 0)
                recv_stall <= $urandom_range(1, 11);
        end
    end

    always @(posedge clk)
    begin
        logic [OUT_W-1:0] want;
        int               off, w;
        bit               bad;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            frames_checked <= frames_checked + 1;
            if (frames_expected.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected frame transfer: %h", m_axis_tdata);
            end
            else
            begin
                want = frames_expected.pop_front();
                bad = 0;
                for (int f = 0; f < 12; f++)
                begin
                    off = (f < 3) ? POS_W * f : 3 * POS_W + VEC_W * (f - 3);
                    w = (f < 3) ? POS_W : VEC_W;
                    if (((want ^ m_axis_tdata) >> off) & ((216'd1 << w) - 1))
                    begin
                        bad = 1;
                        if (mismatches < 10)
                            $display("frame %0d field %0d: expected %h, got %h", frames_checked,
                                     f, (want >> off) & ((216'd1 << w) - 1),
                                     (m_axis_tdata >> off) & ((216'd1 << w) - 1));
                    end
                end
                if (bad)
                    mismatches = mismatches + 1;
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic reg_write(input int idx, input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'(8 * idx);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        start_regs[idx] = (idx < 3) ? (value & 64'hFF_FFFF) : (value & 64'hFFFF_FFFF_FFFF);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_steps.size() != 0 || s_axis_tvalid || frames_expected.size() != 0)
            @(posedge clk);
        // let the block return to idle after its last frame
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [47:0] pack_dir(input int x, input int y, input int z);
        return {x[15:0], y[15:0], z[15:0]};
    endfunction

    function automatic logic [47:0] pick_vector();
        int a, sg;
        a = $urandom_range(0, 2);
        sg = $urandom_range(0, 1) ? UNIT : -UNIT;
        case ($urandom_range(0, 5))
            0: return 48'({$urandom, $urandom});
            1: return pack_dir(11585, -11585, 0);
            default: return pack_dir(a == 0 ? sg : 0, a == 1 ? sg : 0, a == 2 ? sg : 0);
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return POS_W'($urandom);
            1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            default: return POS_W'($signed($urandom_range(0, 131071)) - 65536);
        endcase
    endfunction

    task automatic add_step(input mode_t m, input int px, input int py, input int pz,
                            input int ang);
        step_req_t st;
        st.mode = m;
        st.piv[0] = px[POS_W-1:0];
        st.piv[1] = py[POS_W-1:0];
        st.piv[2] = pz[POS_W-1:0];
        st.angle = ang[15:0];
        if (m == MODE_ROT_UP || m == MODE_ROT_RIGHT)
            rotations_sent++;
        pending_steps.push_back(st);
    endtask

    task automatic add_random_steps(input int n);
        int r;
        mode_t m;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 39);
            m = (r == 0) ? MODE_HOLD : (r < 3) ? MODE_RELOAD :
                (r < 21) ? MODE_ROT_UP : MODE_ROT_RIGHT;
            add_step(m, pick_coord(), pick_coord(), pick_coord(), $urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idling_on = 1'b1;
        hold_request = 1'b0;
        mismatches = 0;
        frames_checked = 0;
        steps_sent = 0;
        rotations_sent = 0;
        cycle_count = 0;
        start_regs[0] = 0;
        start_regs[1] = 0;
        start_regs[2] = 0;
        start_regs[3] = pack_dir(0, 0, -UNIT);
        start_regs[4] = pack_dir(0, UNIT, 0);
        start_regs[5] = pack_dir(UNIT, 0, 0);
        load_start_frame();
        repeat (7) @(posedge clk);
        rst_n = 1'b1;

        // default frame: angle extremes, quarter-turn fold edges, unused mode, saturation
        add_step(MODE_ROT_UP, 0, 0, 0, 0);
        add_step(MODE_ROT_UP, 0, 0, 0, 12868);
        add_step(MODE_ROT_RIGHT, 4096, -4096, 0, 12869);
        add_step(MODE_ROT_UP, 0, 0, 0, 32767);
        add_step(MODE_ROT_RIGHT, 0, 0, 0, -32768);
        add_step(MODE_ROT_UP, 0, 0, 0, -12869);
        add_step(MODE_HOLD, -1, 8388607, -8388608, -1);
        add_step(MODE_ROT_UP, 8388607, 8388607, 8388607, 12868);
        add_step(MODE_ROT_RIGHT, -8388608, -8388608, -8388608, -12868);
        add_step(MODE_ROT_UP, -8388608, 8388607, 0, 25736);
        add_step(MODE_RELOAD, 0, 0, 0, 0);
        wait_drained();

        // non-unit up axis and a zero right vector, position at the ends of the range
        reg_write(REG_POS_X, 64'h7F_FFFF);
        reg_write(REG_POS_Y, 64'h80_0000);
        reg_write(REG_POS_Z, 64'hFFFF_FFFF_FF7F_FFFF);
        reg_write(REG_HEADING, pack_dir(0, 0, UNIT));
        reg_write(REG_UPWARD, pack_dir(UNIT, UNIT, 0));
        reg_write(REG_SIDEWAYS, 0);
        add_step(MODE_RELOAD, 0, 0, 0, 0);
        add_step(MODE_ROT_UP, -8388608, 0, 8388607, 5000);
        add_step(MODE_ROT_RIGHT, 0, 0, 0, 3000);
        add_step(MODE_ROT_UP, 100, -100, 7, -7000);
        add_step(MODE_ROT_UP, 0, 0, 0, 32767);
        add_step(MODE_RELOAD, 0, 0, 0, 0);
        wait_drained();

        // random phases, each with fresh start registers
        for (int ph = 0; ph < 8; ph++)
        begin
            for (int i = 0; i < 3; i++)
                reg_write(i, ph == 0 ? 64'h80_0000 : ph == 1 ? 64'h7F_FFFF :
                             ph == 2 ? 64'h0 : {$urandom, $urandom});
            reg_write(REG_HEADING, ph == 1 ? 48'hFFFF_FFFF_FFFF : pick_vector());
            reg_write(REG_UPWARD, ph == 2 ? 48'h0 : pick_vector());
            reg_write(REG_SIDEWAYS, ph == 1 ? 48'h8000_8000_8000 : pick_vector());
            add_step(MODE_RELOAD, 0, 0, 0, 0);
            if (ph == 3)
                hold_request = 1'b1;
            if (ph == 7)
                idling_on = 1'b0;
            add_random_steps(203);
            wait_drained();
        end

        repeat (300) @(posedge clk);
        $display("covered %0d steps (%0d rotations) over 10 register settings, %0d frames checked",
                 steps_sent, rotations_sent, frames_checked);
        if (mismatches == 0)
            $display("[camera_orbit_rotation_top] OK");
        else
            $display("[camera_orbit_rotation_top] ERROR");
        $finish;
    end

endmodule

/* sim.f */
design/cor_pkg.sv
design/cor_cordic.sv
design/camera_orbit_rotation_top.sv
verif/camera_orbit_rotation_top_tb.sv
